// ===== hw/rtl/mc_pkg.sv =====
// Shared types, character constants and code tables for the Morse converter.
// Used by mc_decoder, mc_serializer and morse_codec; depends on nothing else.
`default_nettype none

package mc_pkg;

   // Character codes that the converter reads or produces.
   localparam logic [7:0] SPACE_CHAR   = 8'h20;
   localparam logic [7:0] UNKNOWN_CHAR = 8'h23;
   localparam logic [7:0] DOT_CHAR     = 8'h2E;
   localparam logic [7:0] DASH_CHAR    = 8'h2D;
   localparam logic [7:0] LOWER_A      = 8'h61;
   localparam logic [7:0] LOWER_Z      = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;
   localparam logic [7:0] TABLE_LAST   = 8'h5F;

   // Longest code in the table and the beat counter that covers it plus a space.
   localparam int CODE_LEN_MAX         = 7;
   localparam int LEN_W                = 3;
   localparam int BEAT_W               = 4;
   localparam int TABLE_SIZE           = 64;
   localparam int MAX_CODE_LEN_DEFAULT = 7;

   // One table entry: symbol count and symbols, first symbol in the highest used bit.
   typedef struct packed {
      logic [LEN_W-1:0]        len;
      logic [CODE_LEN_MAX-1:0] bits;
   } code_entry_type;

   // Reverse table, keyed by a marker one above the symbols.
   typedef logic [255:0][7:0] rom_type;

   // Decoder controls and result.
   typedef struct packed {
      logic       step;
      logic       flush;
      logic       last;
      logic [7:0] data;
   } dec_ctrl_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } dec_result_type;

   // Serializer controls and status.
   typedef struct packed {
      logic       load;
      logic       encode;
      logic       out_free;
      logic [7:0] data;
   } ser_ctrl_type;

   typedef struct packed {
      logic       ready;
      logic       beat_valid;
      logic       beat_last;
      logic [7:0] beat_data;
   } ser_status_type;

   // Code table for characters 0x20..0x5F; dot is 0 and dash is 1.
   function automatic code_entry_type code_of(input logic [5:0] idx);
      code_entry_type e;
      case (idx)
         6'd1:  e = '{3'd6, 7'b0101011};
         6'd2:  e = '{3'd6, 7'b0010010};
         6'd4:  e = '{3'd7, 7'b0001001};
         6'd6:  e = '{3'd5, 7'b0001000};
         6'd7:  e = '{3'd6, 7'b0011110};
         6'd8:  e = '{3'd5, 7'b0010110};
         6'd9:  e = '{3'd6, 7'b0101101};
         6'd11: e = '{3'd5, 7'b0001010};
         6'd12: e = '{3'd6, 7'b0110011};
         6'd13: e = '{3'd6, 7'b0100001};
         6'd14: e = '{3'd6, 7'b0010101};
         6'd15: e = '{3'd5, 7'b0010010};
         6'd16: e = '{3'd5, 7'b0011111};
         6'd17: e = '{3'd5, 7'b0001111};
         6'd18: e = '{3'd5, 7'b0000111};
         6'd19: e = '{3'd5, 7'b0000011};
         6'd20: e = '{3'd5, 7'b0000001};
         6'd21: e = '{3'd5, 7'b0000000};
         6'd22: e = '{3'd5, 7'b0010000};
         6'd23: e = '{3'd5, 7'b0011000};
         6'd24: e = '{3'd5, 7'b0011100};
         6'd25: e = '{3'd5, 7'b0011110};
         6'd26: e = '{3'd6, 7'b0111000};
         6'd27: e = '{3'd6, 7'b0101010};
         6'd29: e = '{3'd5, 7'b0010001};
         6'd31: e = '{3'd6, 7'b0001100};
         6'd32: e = '{3'd6, 7'b0011010};
         6'd33: e = '{3'd2, 7'b0000001};
         6'd34: e = '{3'd4, 7'b0001000};
         6'd35: e = '{3'd4, 7'b0001010};
         6'd36: e = '{3'd3, 7'b0000100};
         6'd37: e = '{3'd1, 7'b0000000};
         6'd38: e = '{3'd4, 7'b0000010};
         6'd39: e = '{3'd3, 7'b0000110};
         6'd40: e = '{3'd4, 7'b0000000};
         6'd41: e = '{3'd2, 7'b0000000};
         6'd42: e = '{3'd4, 7'b0000111};
         6'd43: e = '{3'd3, 7'b0000101};
         6'd44: e = '{3'd4, 7'b0000100};
         6'd45: e = '{3'd2, 7'b0000011};
         6'd46: e = '{3'd2, 7'b0000010};
         6'd47: e = '{3'd3, 7'b0000111};
         6'd48: e = '{3'd4, 7'b0000110};
         6'd49: e = '{3'd4, 7'b0001101};
         6'd50: e = '{3'd3, 7'b0000010};
         6'd51: e = '{3'd3, 7'b0000000};
         6'd52: e = '{3'd1, 7'b0000001};
         6'd53: e = '{3'd3, 7'b0000001};
         6'd54: e = '{3'd4, 7'b0000001};
         6'd55: e = '{3'd3, 7'b0000011};
         6'd56: e = '{3'd4, 7'b0001001};
         6'd57: e = '{3'd4, 7'b0001011};
         6'd58: e = '{3'd4, 7'b0001100};
         6'd63: e = '{3'd6, 7'b0001101};
         default: e = '{3'd0, 7'b0000000};
      endcase
      return e;
   endfunction

   // Builds the reverse table; lower table positions win on equal codes.
   function automatic rom_type build_decode_rom();
      rom_type        rom;
      code_entry_type e;
      logic [7:0]     key;
      for (int k = 0; k < 256; k++) begin
         rom[k] = UNKNOWN_CHAR;
      end
      for (int j = TABLE_SIZE - 1; j >= 1; j--) begin
         e = code_of(6'(j));
         if (e.len != '0) begin
            key      = (8'(1) << e.len) | 8'(e.bits);
            rom[key] = 8'(j) + SPACE_CHAR;
         end
      end
      return rom;
   endfunction

   localparam rom_type DECODE_ROM = build_decode_rom();

endpackage

`default_nettype wire

// ===== hw/rtl/mc_decoder.sv =====
// Symbol gatherer for the decode direction: shifts in one dot or dash per byte
// and looks up the closed letter. Depends on mc_pkg.
`default_nettype none

module mc_decoder
   import mc_pkg::*;
#(
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEFAULT
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire dec_ctrl_type   ctrl,
   output dec_result_type      result
);

   localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [MAX_CODE_LEN-1:0] bits_ff, bits_in;
   logic                    bad_ff, bad_in;
   logic                    lone_ff, lone_in;

   logic                    is_space, is_dot, is_dash, pending;
   logic [CNT_W-1:0]        s1_count, l_count;
   logic [MAX_CODE_LEN-1:0] s1_bits, l_bits;
   logic                    s1_bad, s1_lone, l_bad, l_lone;
   logic [7:0]              key;
   logic [7:0]              letter_data;

   // Letter state after taking this byte, and the letter that a space closes.
   always_comb begin
      is_space = ctrl.data == SPACE_CHAR;
      is_dot   = ctrl.data == DOT_CHAR;
      is_dash  = ctrl.data == DASH_CHAR;
      pending  = (count_ff != '0) || bad_ff || lone_ff;

      s1_count = count_ff;
      s1_bits  = bits_ff;
      s1_bad   = bad_ff || lone_ff;
      s1_lone  = 1'b0;
      if (is_space) begin
         // A space with nothing pending opens a lone gap.
         s1_count = '0;
         s1_bits  = '0;
         s1_bad   = 1'b0;
         s1_lone  = 1'b1;
      end else if (is_dot || is_dash) begin
         if (count_ff < CNT_W'(MAX_CODE_LEN)) begin
            s1_bits  = {bits_ff[MAX_CODE_LEN-2:0], is_dash};
            s1_count = count_ff + CNT_W'(1);
         end else begin
            s1_bad = 1'b1;
         end
      end else begin
         s1_bad = 1'b1;
      end

      if (is_space && pending) begin
         l_count = count_ff;
         l_bits  = bits_ff;
         l_bad   = bad_ff;
         l_lone  = lone_ff;
      end else begin
         l_count = s1_count;
         l_bits  = s1_bits;
         l_bad   = s1_bad;
         l_lone  = s1_lone;
      end

      key = (8'(1) << l_count) | 8'(l_bits);
      if (l_lone && (l_count == '0) && !l_bad) begin
         letter_data = SPACE_CHAR;
      end else if (l_bad || (l_count > CNT_W'(CODE_LEN_MAX))) begin
         letter_data = UNKNOWN_CHAR;
      end else begin
         letter_data = DECODE_ROM[key];
      end

      result.valid = ctrl.step && (is_space ? (pending || ctrl.last) : ctrl.last);
      result.data  = letter_data;
   end

   // Next letter state: cleared at the end of a message or when a letter closes.
   always_comb begin
      count_in = count_ff;
      bits_in  = bits_ff;
      bad_in   = bad_ff;
      lone_in  = lone_ff;
      if (ctrl.flush || (ctrl.step && ctrl.last) || (ctrl.step && is_space && pending)) begin
         count_in = '0;
         bits_in  = '0;
         bad_in   = 1'b0;
         lone_in  = 1'b0;
      end else if (ctrl.step) begin
         count_in = s1_count;
         bits_in  = s1_bits;
         bad_in   = s1_bad;
         lone_in  = s1_lone;
      end
   end

   // Letter state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bits_ff  <= '0;
         bad_ff   <= 1'b0;
         lone_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         bits_ff  <= bits_in;
         bad_ff   <= bad_in;
         lone_ff  <= lone_in;
      end
   end

   // A lone gap never carries symbols or a bad mark.
   a_lone_clean: assert property (@(posedge clock) disable iff (reset)
      lone_ff |-> ((count_ff == '0) && !bad_ff))
      else $error("lone gap holds symbols");

   // The end of a message leaves no pending letter.
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (ctrl.flush || (ctrl.step && ctrl.last)) |=>
         ((count_ff == '0) && !bad_ff && !lone_ff))
      else $error("letter state survived end of message");

   // The symbol count stays within the longest accepted letter.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_CODE_LEN))
      else $error("symbol count overflow");

endmodule

`default_nettype wire

// ===== hw/rtl/mc_serializer.sv =====
// Result serializer (uses mc_pkg): loads an encoded character or decoded byte
// and hands out one result byte per free cycle from a symbol shift register.
`default_nettype none

module mc_serializer
   import mc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire ser_ctrl_type   ctrl,
   input  wire dec_result_type dec,
   output ser_status_type      status
);

   typedef enum logic [1:0] {
      KIND_MORSE,
      KIND_SPACES,
      KIND_CHAR
   } kind_type;

   kind_type                kind_ff, kind_in;
   logic [CODE_LEN_MAX-1:0] sym_ff, sym_in;
   logic [BEAT_W-1:0]       left_ff, left_in;
   logic [7:0]              data_ff, data_in;

   logic [7:0]              folded;
   logic                    in_range;
   logic [5:0]              idx;
   code_entry_type          entry;
   logic                    advance;

   // Fold lower case and find the table entry of the incoming byte.
   always_comb begin
      folded = ctrl.data;
      if ((ctrl.data >= LOWER_A) && (ctrl.data <= LOWER_Z)) begin
         folded = ctrl.data - CASE_OFFSET;
      end
      in_range = (folded >= SPACE_CHAR) && (folded <= TABLE_LAST);
      idx      = 6'(folded - SPACE_CHAR);
      entry    = code_of(idx);
   end

   assign advance = ctrl.out_free && (left_ff != '0);

   // Load a new run of result bytes, or shift out one symbol.
   always_comb begin
      kind_in = kind_ff;
      sym_in  = sym_ff;
      left_in = left_ff;
      data_in = data_ff;
      if (ctrl.load) begin
         left_in = '0;
         if (ctrl.encode) begin
            if (in_range && (idx == '0)) begin
               kind_in = KIND_SPACES;
               left_in = BEAT_W'(2);
            end else if (in_range && (entry.len != '0)) begin
               kind_in = KIND_MORSE;
               sym_in  = entry.bits << (LEN_W'(CODE_LEN_MAX) - entry.len);
               left_in = BEAT_W'(entry.len) + BEAT_W'(1);
            end
         end else if (dec.valid) begin
            kind_in = KIND_CHAR;
            data_in = dec.data;
            left_in = BEAT_W'(1);
         end
      end else if (advance) begin
         left_in = left_ff - BEAT_W'(1);
         sym_in  = {sym_ff[CODE_LEN_MAX-2:0], 1'b0};
      end
   end

   // Byte of the current beat; a Morse run ends with a space.
   always_comb begin
      case (kind_ff)
         KIND_MORSE: begin
            if (left_ff > BEAT_W'(1)) begin
               status.beat_data = sym_ff[CODE_LEN_MAX-1] ? DASH_CHAR : DOT_CHAR;
            end else begin
               status.beat_data = SPACE_CHAR;
            end
         end
         KIND_SPACES: status.beat_data = SPACE_CHAR;
         KIND_CHAR:   status.beat_data = data_ff;
         default:     status.beat_data = SPACE_CHAR;
      endcase
      status.beat_valid = left_ff != '0;
      status.beat_last  = left_ff == BEAT_W'(1);
      status.ready      = (left_ff == '0) || ((left_ff == BEAT_W'(1)) && ctrl.out_free);
   end

   // Beat counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      sym_ff  <= sym_in;
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/morse_codec.sv =====
// Top level of the streaming Morse converter: mode register, output register,
// and the mc_decoder and mc_serializer units. Depends on mc_pkg.
//
// Converts ASCII text to Morse symbols ('.', '-', ' ') when encode_mode is 1
// (reset value) and Morse symbols back to text when it is 0; write the mode
// through csr_wr_en/csr_wr_data only while the block is idle. Results leave
// one byte per cycle while the output is free, from a symbol shift register;
// an encoded character keeps the input closed while its run of result bytes
// goes out, a decoded byte while its result does, a dropped byte not at all.
// The output register lets the next transaction in while the final result of
// the previous one still waits on rsp_tready. rsp_tlast marks the last result
// of each input transaction. The decoder gathers one symbol per byte, so
// letters of up to MAX_CODE_LEN symbols are held; longer ones decode as '#'.
`default_nettype none

module morse_codec
   import mc_pkg::*;
#(
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // Configuration: bit 0 is encode_mode.
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data,
   // Input stream.
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_char
   input  wire logic       req_tlast,   // last_in
   // Result stream.
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_char
   output logic            rsp_tlast    // last_out
);

   logic           encode_mode_ff, encode_mode_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff;
   logic           rsp_last_ff;

   logic           req_fire;
   logic           out_free;
   logic           advance;
   dec_ctrl_type   dec_ctrl;
   dec_result_type dec_result;
   ser_ctrl_type   ser_ctrl;
   ser_status_type ser_status;

   // Mode register.
   assign encode_mode_in = csr_wr_en ? csr_wr_data : encode_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         encode_mode_ff <= 1'b1;
      end else begin
         encode_mode_ff <= encode_mode_in;
      end
   end

   // Input transaction and unit controls.
   assign req_tready = ser_status.ready;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = ser_status.beat_valid && out_free;

   always_comb begin
      dec_ctrl.step   = req_fire && !encode_mode_ff;
      dec_ctrl.flush  = req_fire && encode_mode_ff && req_tlast;
      dec_ctrl.last   = req_tlast;
      dec_ctrl.data   = req_tdata;
      ser_ctrl.load     = req_fire;
      ser_ctrl.encode   = encode_mode_ff;
      ser_ctrl.out_free = out_free;
      ser_ctrl.data     = req_tdata;
   end

   mc_decoder #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_decoder (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (dec_ctrl),
      .result (dec_result)
   );

   mc_serializer u_serializer (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ser_ctrl),
      .dec    (dec_result),
      .status (ser_status)
   );

   // Output register.
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= ser_status.beat_data;
         rsp_last_ff <= ser_status.beat_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A decode transaction produces at most one result.
   a_decode_single: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !encode_mode_ff) |=> (!ser_status.beat_valid || ser_status.beat_last))
      else $error("decode produced more than one result");

   // Every encoded run closes with a space.
   a_encode_ends_space: assert property (@(posedge clock) disable iff (reset)
      (advance && ser_status.beat_last && encode_mode_ff) |->
         (ser_status.beat_data == SPACE_CHAR))
      else $error("encoded run does not end in a space");

   // Inside an encoded run only dots, dashes and spaces appear.
   a_encode_alphabet: assert property (@(posedge clock) disable iff (reset)
      (ser_status.beat_valid && encode_mode_ff) |->
         ((ser_status.beat_data == DOT_CHAR) || (ser_status.beat_data == DASH_CHAR) ||
          (ser_status.beat_data == SPACE_CHAR)))
      else $error("encoded byte outside the Morse alphabet");

endmodule

`default_nettype wire
